// File: src/assert_macros.svh
// Assertion macros for the RTL top level.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/sopg_pkg.sv
// Constants and codes for the sprite object pixel generator.
// No dependencies.
`default_nettype none

package sopg_pkg;

    localparam int RESET_MIN_PLAYER   = 3;
    localparam int RESET_MIN_OTHER    = 2;
    localparam int RESET_DELAY_PLAYER = 5;
    localparam int RESET_DELAY_OTHER  = 4;

    localparam logic [8:0] LINE_PIXELS  = 9'd160;
    localparam logic [7:0] BLANK_CLOCKS = 8'd68;

    localparam logic [7:0] POS_MIN_PLAYER   = 8'(RESET_MIN_PLAYER % 160);
    localparam logic [7:0] POS_MIN_OTHER    = 8'(RESET_MIN_OTHER % 160);
    localparam logic [7:0] POS_DELAY_PLAYER = 8'(RESET_DELAY_PLAYER);
    localparam logic [7:0] POS_DELAY_OTHER  = 8'(RESET_DELAY_OTHER);

    // request codes (tuser)
    localparam logic [1:0] REQ_QUERY  = 2'd0;
    localparam logic [1:0] REQ_RESET  = 2'd1;
    localparam logic [1:0] REQ_MOTION = 2'd2;

    // object kinds
    localparam logic [1:0] KIND_PLAYER  = 2'd0;
    localparam logic [1:0] KIND_MISSILE = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_OBJECT_KIND  = 3'd0;
    localparam logic [2:0] CFG_SIZE_MODE    = 3'd1;
    localparam logic [2:0] CFG_BALL_CONTROL = 3'd2;
    localparam logic [2:0] CFG_GRAPHICS     = 3'd3;
    localparam logic [2:0] CFG_REFLECT      = 3'd4;

    // copy layouts, size_mode[2:0]
    localparam logic [2:0] MODE_TWO_CLOSE   = 3'd1;
    localparam logic [2:0] MODE_TWO_MED     = 3'd2;
    localparam logic [2:0] MODE_THREE_CLOSE = 3'd3;
    localparam logic [2:0] MODE_TWO_WIDE    = 3'd4;
    localparam logic [2:0] MODE_DOUBLE      = 3'd5;
    localparam logic [2:0] MODE_THREE_MED   = 3'd6;
    localparam logic [2:0] MODE_QUAD        = 3'd7;

    localparam logic [7:0] GAP_CLOSE = 8'd16;
    localparam logic [7:0] GAP_MED   = 8'd32;
    localparam logic [7:0] GAP_WIDE  = 8'd64;

endpackage

`default_nettype wire

// File: src/sprite_object_pixel_generator_unit.sv
// Top level of the sprite object pixel generator: position keeping and pixel test.
// Depends on sopg_pkg and assert_macros.svh.
//
// Usage:
//  - Input stream: s_axis_tuser carries the request code (0 pixel query,
//    1 position reset strobe, 2 motion apply); s_axis_tdata carries
//    pixel_x, color_clock and motion. A transfer happens when tvalid and
//    tready are both high.
//  - Output stream: one result per input transfer, in order, carrying
//    drawing, in_copy, copy_offset and the position after that item.
//  - Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
//    (0 kind, 1 size mode, 2 ball control, 3 graphics, 4 reflect). Write
//    only while no item is in flight.
//  - Throughput: one item per cycle while the output is not stalled; the
//    position register closes its feedback loop through a single compute
//    stage, so strobes and queries may be interleaved freely. An item
//    passes the input register, then the result register, before its result is valid.
//  - Stall: when m_axis_tready is low the result holds and one more item
//    is held in the input register; s_axis_tready then drops.
//  - Reset: synchronous, active low; clears valids, the configuration
//    registers and the position to 0.
`default_nettype none
`include "assert_macros.svh"

module sprite_object_pixel_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // pixel_x[7:0], color_clock[15:8], motion[23:16]
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // drawing[0], in_copy[1], copy_offset[6:2],
                                            // position[14:7], zero[15]
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    // configuration
    logic [1:0] r_kind;
    logic [7:0] r_size_mode;
    logic [7:0] r_ball_ctrl;
    logic [7:0] r_graphics;
    logic       r_reflect;

    // input stage
    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic [7:0] r_in_x;
    logic [7:0] r_in_cc;
    logic [7:0] r_in_mv;

    // state and result
    logic       r_out_valid;
    logic       r_out_drawing;
    logic       r_out_in_copy;
    logic [4:0] r_out_offset;
    logic [7:0] r_position;

    logic       w_advance;
    logic       w_in_take;

    logic       n_drawing;
    logic       n_in_copy;
    logic [4:0] n_offset;
    logic [7:0] n_position;

    logic       w_is_player;
    logic       w_is_ball;
    logic [2:0] w_mode;
    logic [1:0] w_scale_sh;
    logic [5:0] w_width;
    logic [7:0] w_gap_a;
    logic [7:0] w_gap_b;
    logic       w_has_a;
    logic       w_has_b;
    logic [7:0] w_start_a;
    logic [7:0] w_start_b;
    logic [7:0] w_d0;
    logic [7:0] w_d1;
    logic [7:0] w_d2;
    logic       w_hit0;
    logic       w_hit1;
    logic       w_hit2;
    logic [7:0] w_hit_d;
    logic [2:0] w_bit;
    logic [2:0] w_sh;
    logic [8:0] w_rst_sum;
    logic [3:0] w_nib;
    logic [8:0] w_mv_sum;

    function automatic logic [7:0] wrap_line(input logic [8:0] v);
        wrap_line = (v >= sopg_pkg::LINE_PIXELS) ? 8'(v - sopg_pkg::LINE_PIXELS) : v[7:0];
    endfunction

    function automatic logic [7:0] line_dist(input logic [7:0] x, input logic [7:0] s);
        line_dist = (x >= s) ? 8'(x - s)
                             : 8'({1'b0, x} + sopg_pkg::LINE_PIXELS - {1'b0, s});
    endfunction

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_position, r_out_offset, r_out_in_copy, r_out_drawing};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= '0;
            r_size_mode <= '0;
            r_ball_ctrl <= '0;
            r_graphics  <= '0;
            r_reflect   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sopg_pkg::CFG_OBJECT_KIND:  r_kind      <= i_cfg_wdata[1:0];
                sopg_pkg::CFG_SIZE_MODE:    r_size_mode <= i_cfg_wdata;
                sopg_pkg::CFG_BALL_CONTROL: r_ball_ctrl <= i_cfg_wdata;
                sopg_pkg::CFG_GRAPHICS:     r_graphics  <= i_cfg_wdata;
                sopg_pkg::CFG_REFLECT:      r_reflect   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_req <= s_axis_tuser;
            r_in_x   <= s_axis_tdata[7:0];
            r_in_cc  <= s_axis_tdata[15:8];
            r_in_mv  <= s_axis_tdata[23:16];
        end
    end

    // pixel test
    always_comb begin
        w_is_player = (r_kind == sopg_pkg::KIND_PLAYER);
        w_is_ball   = r_kind[1];
        w_mode      = r_size_mode[2:0];

        case (w_mode)
            sopg_pkg::MODE_DOUBLE: w_scale_sh = 2'd1;
            sopg_pkg::MODE_QUAD:   w_scale_sh = 2'd2;
            default:               w_scale_sh = 2'd0;
        endcase

        if (w_is_player) begin
            w_width = 6'd8 << w_scale_sh;
        end else if (w_is_ball) begin
            w_width = 6'd1 << r_ball_ctrl[5:4];
        end else begin
            w_width = 6'd1 << r_size_mode[5:4];
        end

        w_gap_a = '0;
        w_gap_b = '0;
        w_has_a = 1'b0;
        w_has_b = 1'b0;
        case (w_mode)
            sopg_pkg::MODE_TWO_CLOSE: begin
                w_gap_a = sopg_pkg::GAP_CLOSE;
                w_has_a = 1'b1;
            end
            sopg_pkg::MODE_TWO_MED: begin
                w_gap_a = sopg_pkg::GAP_MED;
                w_has_a = 1'b1;
            end
            sopg_pkg::MODE_THREE_CLOSE: begin
                w_gap_a = sopg_pkg::GAP_CLOSE;
                w_gap_b = sopg_pkg::GAP_MED;
                w_has_a = 1'b1;
                w_has_b = 1'b1;
            end
            sopg_pkg::MODE_TWO_WIDE: begin
                w_gap_a = sopg_pkg::GAP_WIDE;
                w_has_a = 1'b1;
            end
            sopg_pkg::MODE_THREE_MED: begin
                w_gap_a = sopg_pkg::GAP_MED;
                w_gap_b = sopg_pkg::GAP_WIDE;
                w_has_a = 1'b1;
                w_has_b = 1'b1;
            end
            default: ;
        endcase
        if (w_is_ball) begin
            w_has_a = 1'b0;
            w_has_b = 1'b0;
        end

        w_start_a = wrap_line({1'b0, r_position} + {1'b0, w_gap_a});
        w_start_b = wrap_line({1'b0, r_position} + {1'b0, w_gap_b});

        w_d0 = line_dist(r_in_x, r_position);
        w_d1 = line_dist(r_in_x, w_start_a);
        w_d2 = line_dist(r_in_x, w_start_b);

        w_hit0 = (w_d0 < {2'b00, w_width});
        w_hit1 = w_has_a && (w_d1 < {2'b00, w_width});
        w_hit2 = w_has_b && (w_d2 < {2'b00, w_width});

        if (w_hit0) begin
            w_hit_d = w_d0;
        end else if (w_hit1) begin
            w_hit_d = w_d1;
        end else begin
            w_hit_d = w_d2;
        end

        w_bit = 3'(w_hit_d >> w_scale_sh);
        w_sh  = r_reflect ? w_bit : 3'd7 - w_bit;
    end

    // position update and result fields
    always_comb begin
        w_rst_sum = {1'b0, r_in_cc} - {1'b0, sopg_pkg::BLANK_CLOCKS}
                  + (w_is_player ? {1'b0, sopg_pkg::POS_DELAY_PLAYER}
                                 : {1'b0, sopg_pkg::POS_DELAY_OTHER});
        w_nib     = r_in_mv[7:4];
        if (w_nib[3]) begin
            w_mv_sum = {1'b0, r_position} + 9'(5'd16 - {1'b0, w_nib});
        end else begin
            w_mv_sum = {1'b0, r_position} + sopg_pkg::LINE_PIXELS - {5'd0, w_nib};
        end

        n_drawing  = 1'b0;
        n_in_copy  = 1'b0;
        n_offset   = '0;
        n_position = r_position;
        case (r_in_req)
            sopg_pkg::REQ_QUERY: begin
                n_in_copy = w_hit0 || w_hit1 || w_hit2;
                if (n_in_copy) begin
                    n_offset  = w_hit_d[4:0];
                    n_drawing = w_is_player ? r_graphics[w_sh] : 1'b1;
                end
            end
            sopg_pkg::REQ_RESET: begin
                if (r_in_cc < sopg_pkg::BLANK_CLOCKS) begin
                    n_position = w_is_player ? sopg_pkg::POS_MIN_PLAYER
                                             : sopg_pkg::POS_MIN_OTHER;
                end else begin
                    n_position = wrap_line(w_rst_sum);
                end
            end
            sopg_pkg::REQ_MOTION: begin
                n_position = wrap_line(w_mv_sum);
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_position  <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_position <= n_position;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_drawing <= n_drawing;
            r_out_in_copy <= n_in_copy;
            r_out_offset  <= n_offset;
        end
    end

    `ASSERT_IMPL(a_pos_in_line, 1'b1, {1'b0, r_position} < sopg_pkg::LINE_PIXELS)
    `ASSERT_IMPL(a_miss_clean, r_out_valid && !r_out_in_copy, (r_out_offset == 5'd0) && !r_out_drawing)
    `ASSERT_NEXT(a_stall_keeps_item, r_in_valid && r_out_valid && !m_axis_tready, r_in_valid)
    `ASSERT_NEXT(a_query_keeps_pos, w_advance && r_in_valid && (r_in_req == sopg_pkg::REQ_QUERY), r_position == $past(r_position))

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Regression bench for sprite_object_pixel_generator_unit: directed strobes, motions and queries,
// then random traffic over sixteen register settings with random stalls on both streams in most phases.
// Depends on sopg_pkg and the RTL top level only.
`timescale 1ns / 100ps

module testbench;

    localparam int LINE = sopg_pkg::LINE_PIXELS;
    localparam int BLANK = sopg_pkg::BLANK_CLOCKS;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 16;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic [7:0] position;
        logic [4:0] offset;
        logic       in_copy;
        logic       drawing;
    } t_pixel_result;

    // Tracks object state and registers; holds expected results in order.
    class object_pixel_tracker;
        logic [1:0] kind;
        logic [7:0] size_mode;
        logic [7:0] ball_ctrl;
        logic [7:0] graphics;
        logic       reflect_on;
        logic [7:0] position;
        t_pixel_result expected_pixels[$];
        int mismatches;

        function void write_reg(logic [2:0] addr, logic [7:0] val);
            case (addr)
                sopg_pkg::CFG_OBJECT_KIND:  kind = val[1:0];
                sopg_pkg::CFG_SIZE_MODE:    size_mode = val;
                sopg_pkg::CFG_BALL_CONTROL: ball_ctrl = val;
                sopg_pkg::CFG_GRAPHICS:     graphics = val;
                sopg_pkg::CFG_REFLECT:      reflect_on = val[0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [1:0] req, logic [7:0] x, logic [7:0] cc,
                                   logic [7:0] mv);
            t_pixel_result r;
            int starts[3];
            int scale, width, n, d, bit_idx, sh, p, gap_a, gap_b, nib, delay;
            logic is_player, is_ball;
            r = '0;
            is_player = (kind == sopg_pkg::KIND_PLAYER);
            is_ball = !is_player && (kind != sopg_pkg::KIND_MISSILE);
            p = int'(position) % LINE;
            case (req)
                sopg_pkg::REQ_QUERY: begin
                    case (size_mode[2:0])
                        sopg_pkg::MODE_DOUBLE: scale = 2;
                        sopg_pkg::MODE_QUAD:   scale = 4;
                        default:               scale = 1;
                    endcase
                    gap_a = 0;
                    gap_b = 0;
                    case (size_mode[2:0])
                        sopg_pkg::MODE_TWO_CLOSE:   gap_a = sopg_pkg::GAP_CLOSE;
                        sopg_pkg::MODE_TWO_MED:     gap_a = sopg_pkg::GAP_MED;
                        sopg_pkg::MODE_THREE_CLOSE: begin
                            gap_a = sopg_pkg::GAP_CLOSE;
                            gap_b = sopg_pkg::GAP_MED;
                        end
                        sopg_pkg::MODE_TWO_WIDE:    gap_a = sopg_pkg::GAP_WIDE;
                        sopg_pkg::MODE_THREE_MED:   begin
                            gap_a = sopg_pkg::GAP_MED;
                            gap_b = sopg_pkg::GAP_WIDE;
                        end
                        default: ;
                    endcase
                    if (is_ball) begin
                        gap_a = 0;
                        gap_b = 0;
                    end
                    if (is_player)
                        width = 8 * scale;
                    else if (is_ball)
                        width = 1 << ball_ctrl[5:4];
                    else
                        width = 1 << size_mode[5:4];
                    n = 1;
                    starts[0] = p;
                    if (gap_a != 0) begin
                        starts[n] = (p + gap_a) % LINE;
                        n++;
                    end
                    if (gap_b != 0) begin
                        starts[n] = (p + gap_b) % LINE;
                        n++;
                    end
                    for (int k = 0; k < n; k++) begin
                        d = (int'(x) >= starts[k]) ? int'(x) - starts[k]
                                                   : int'(x) + LINE - starts[k];
                        if (!r.in_copy && d < width) begin
                            r.in_copy = 1'b1;
                            r.offset = 5'(d);
                        end
                    end
                    if (r.in_copy) begin
                        if (is_player) begin
                            bit_idx = (int'(r.offset) / scale) % 8;
                            sh = reflect_on ? bit_idx : 7 - bit_idx;
                            r.drawing = graphics[sh];
                        end else begin
                            r.drawing = 1'b1;
                        end
                    end
                end
                sopg_pkg::REQ_RESET: begin
                    if (int'(cc) < BLANK) begin
                        position = 8'((is_player ? sopg_pkg::RESET_MIN_PLAYER
                                                 : sopg_pkg::RESET_MIN_OTHER) % LINE);
                    end else begin
                        delay = is_player ? sopg_pkg::RESET_DELAY_PLAYER
                                          : sopg_pkg::RESET_DELAY_OTHER;
                        position = 8'((int'(cc) - BLANK + delay) % LINE);
                    end
                end
                sopg_pkg::REQ_MOTION: begin
                    nib = mv[7:4];
                    if (nib < 8)
                        p = (p + LINE - nib) % LINE;
                    else
                        p = (p + 16 - nib) % LINE;
                    position = 8'(p);
                end
                default: ;
            endcase
            r.position = position;
            expected_pixels.push_back(r);
        endfunction

        function void report_field(string field, int exp_val, int act_val);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field, exp_val, act_val);
        endfunction

        function void check_pixel_result(logic [15:0] word);
            t_pixel_result e;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %h", $time, word);
                return;
            end
            e = expected_pixels.pop_front();
            if (word[0] !== e.drawing)
                report_field("drawing", e.drawing, word[0]);
            if (word[1] !== e.in_copy)
                report_field("in_copy", e.in_copy, word[1]);
            if (word[6:2] !== e.offset)
                report_field("copy_offset", e.offset, word[6:2]);
            if (word[14:7] !== e.position)
                report_field("position", e.position, word[14:7]);
            if (word[15] !== 1'b0)
                report_field("pad bit", 0, word[15]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // pixel_x[7:0], color_clock[15:8], motion[23:16]
    logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // drawing[0], in_copy[1], copy_offset[6:2],
                                     // position[14:7], zero[15]
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [7:0]  i_cfg_wdata = '0;

    object_pixel_tracker board = new();
    bit gaps_on = 1'b1;
    int cycle_count = 0;

    sprite_object_pixel_generator_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sprite_object_pixel_generator_unit regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_pixel_result(m_axis_tdata);
    end

    task automatic send_item(input logic [1:0] req, input logic [7:0] x,
                             input logic [7:0] cc, input logic [7:0] mv);
        while (gaps_on && $urandom_range(0, 99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {mv, cc, x};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(req, x, cc, mv);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.expected_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        board.write_reg(addr, val);
    endtask

    task automatic program_phase(input int phase);
        int q, r;
        logic [2:0] mode;
        logic [4:0] upper;
        q = phase / 4;
        r = phase % 4;
        mode = 3'((5 * q + r) % 8);
        upper = (phase == 0) ? 5'h00 : (phase == 6) ? 5'h1F : 5'($urandom);
        write_reg(sopg_pkg::CFG_OBJECT_KIND, {6'($urandom), 2'(r)});
        write_reg(sopg_pkg::CFG_SIZE_MODE, {upper, mode});
        write_reg(sopg_pkg::CFG_BALL_CONTROL,
                  (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom));
        write_reg(sopg_pkg::CFG_GRAPHICS,
                  (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom));
        write_reg(sopg_pkg::CFG_REFLECT, {7'($urandom), phase[2]});
        // unmapped index, must be ignored
        if (phase == 5)
            write_reg(3'(sopg_pkg::CFG_REFLECT + 1 + $urandom_range(0, 2)), 8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        logic [1:0] req;
        logic [7:0] x, cc, mv;
        int pick, gap;
        pick = $urandom_range(0, 99);
        req = (pick < 60) ? sopg_pkg::REQ_QUERY : (pick < 75) ? sopg_pkg::REQ_RESET :
              (pick < 95) ? sopg_pkg::REQ_MOTION : REQ_UNUSED;
        x = 8'($urandom);
        cc = 8'($urandom);
        mv = 8'($urandom);
        // aim half the queries at or near a copy
        if (req == sopg_pkg::REQ_QUERY && $urandom_range(0, 99) < 50) begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = sopg_pkg::GAP_CLOSE;
                2: gap = sopg_pkg::GAP_MED;
                default: gap = sopg_pkg::GAP_WIDE;
            endcase
            x = 8'((int'(board.position) + gap + $urandom_range(0, 33)) % LINE);
        end
        send_item(req, x, cc, mv);
    endtask

    initial begin
        board.kind = sopg_pkg::KIND_PLAYER;
        board.size_mode = '0;
        board.ball_ctrl = '0;
        board.graphics = '0;
        board.reflect_on = 1'b0;
        board.position = '0;
        board.mismatches = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // at reset position: copy at 0
        send_item(sopg_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0);
        wait_drained();

        write_reg(sopg_pkg::CFG_OBJECT_KIND, {6'd0, sopg_pkg::KIND_PLAYER});
        write_reg(sopg_pkg::CFG_SIZE_MODE, {5'd0, sopg_pkg::MODE_THREE_CLOSE});
        write_reg(sopg_pkg::CFG_BALL_CONTROL, 8'h30);
        write_reg(sopg_pkg::CFG_GRAPHICS, 8'hA5);
        write_reg(sopg_pkg::CFG_REFLECT, 8'h00);
        i_cfg_we <= 1'b0;

        // reset strobes: blank edges, last clock and past the line
        send_item(sopg_pkg::REQ_RESET, 8'd0, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_RESET, 8'd0, 8'd67, 8'd0);
        send_item(sopg_pkg::REQ_RESET, 8'd0, 8'd68, 8'd0);
        send_item(sopg_pkg::REQ_RESET, 8'd0, 8'd227, 8'd0);
        send_item(sopg_pkg::REQ_RESET, 8'd0, 8'd255, 8'd0);
        // motion extremes
        send_item(sopg_pkg::REQ_MOTION, 8'd0, 8'd0, 8'h70);
        send_item(sopg_pkg::REQ_MOTION, 8'd0, 8'd0, 8'h80);
        send_item(sopg_pkg::REQ_MOTION, 8'd0, 8'd0, 8'hF0);
        send_item(sopg_pkg::REQ_MOTION, 8'd0, 8'd0, 8'h0F);
        // three copies at 34, 50, 66
        send_item(sopg_pkg::REQ_QUERY, 8'd34, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd41, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd42, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd50, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd73, 8'd0, 8'd0);
        // wrap at the line end, columns past the line
        send_item(sopg_pkg::REQ_RESET, 8'd0, 8'd227, 8'd0);
        send_item(sopg_pkg::REQ_MOTION, 8'd0, 8'd0, 8'h50);
        send_item(sopg_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd159, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd160, 8'd0, 8'd0);
        send_item(sopg_pkg::REQ_QUERY, 8'd255, 8'd0, 8'd0);
        send_item(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        send_item(sopg_pkg::REQ_QUERY, 8'd1, 8'd0, 8'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            program_phase(phase);
            gaps_on = !(phase == 6 || phase == 7);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 3 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_random_item();
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_pixels.size() == 0)
            $display("sprite_object_pixel_generator_unit regression: pass");
        else
            $display("sprite_object_pixel_generator_unit regression: fail");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/sopg_pkg.sv
src/sprite_object_pixel_generator_unit.sv
tb/testbench.sv
